// ===== rtl/core/rlso_pkg.sv =====
// Shared types, codes and defaults for the run-length stack with offset.
`timescale 1ns / 1ps

package rlso_pkg;

  localparam int STACK_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_ADD  = 2'd2,
    KIND_SUB  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [15:0]        repeat_req;
  } in_t;

  typedef struct packed {
    logic signed [32:0] reply;
    logic               reply_is_total;
  } out_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;   // capture the accepted item
    logic push;   // store entry, issue total
    logic ofs;    // apply add/subtract to the offset
    logic reply;  // issue top value, arm the unit walk
    logic step;   // remove units from the top entry
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic pop_go;     // pop has units to remove and the stack is not empty
    logic walk_done;  // the current walk step is the last one
  } stat_t;

endpackage

// ===== rtl/core/rlso_ctrl.sv =====
// Sequencing state machine for the run-length stack.
`timescale 1ns / 1ps

module rlso_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rlso_pkg::kind_t in_kind,
  output logic           in_stall,
  input  rlso_pkg::stat_t stat,
  output rlso_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PUSH  = 5'b00010,
    S_OFS   = 5'b00100,
    S_REPLY = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_kind)
            rlso_pkg::KIND_PUSH: state_nxt = S_PUSH;
            rlso_pkg::KIND_POP:  state_nxt = S_REPLY;
            default:             state_nxt = S_OFS;
          endcase
        end
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OFS: begin
        cmd.ofs   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.reply = 1'b1;
          state_nxt = stat.pop_go ? S_WALK : S_IDLE;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rlso_dp.sv =====
// Datapath: entry memory, depth, unit total, offset and output register.
`timescale 1ns / 1ps

module rlso_dp #(
  parameter int STACK_DEPTH = rlso_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rlso_pkg::in_t   in_data,
  input  rlso_pkg::cmd_t  cmd,
  output rlso_pkg::stat_t stat,
  input  logic            out_stall,
  output logic            out_valid,
  output rlso_pkg::out_t  out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [31:0] val_mem [STACK_DEPTH];
  logic [15:0] rep_mem [STACK_DEPTH];

  rlso_pkg::in_t  item_r;
  rlso_pkg::out_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic [31:0]    total_r, total_nxt;
  logic [31:0]    offset_r, offset_nxt;
  logic [30:0]    units_r, units_nxt;
  logic [31:0]    rd_val_r;
  logic [15:0]    rd_rep_r;

  logic           we_val, we_rep;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [15:0]    wr_rep;
  logic [DW-1:0]  depth_m1, rd_m1;
  logic [30:0]    have;
  logic [31:0]    top;

  assign depth_m1 = depth_r - DW'(1);
  assign rd_m1    = depth_nxt - DW'(1);
  assign rd_addr  = (depth_nxt == '0) ? '0 : rd_m1[AW-1:0];
  assign have     = {15'b0, rd_rep_r};
  assign top      = (depth_r != '0) ? (rd_val_r + offset_r) : 32'd0;

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.pop_go    = (depth_r != '0) && !item_r.value[31] && (item_r.value[30:0] != '0);
  assign stat.walk_done = (have >= units_r) || (depth_r == DW'(1));

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    depth_nxt     = depth_r;
    total_nxt     = total_r;
    offset_nxt    = offset_r;
    units_nxt     = units_r;
    we_val        = 1'b0;
    we_rep        = 1'b0;
    wr_addr       = depth_r[AW-1:0];
    wr_rep        = item_r.repeat_req;

    if (cmd.push) begin
      if ((item_r.repeat_req != '0) && (depth_r != DW'(STACK_DEPTH))) begin
        we_val    = 1'b1;
        we_rep    = 1'b1;
        depth_nxt = depth_r + DW'(1);
        total_nxt = total_r + {16'b0, item_r.repeat_req};
      end
      out_nxt.reply          = {1'b0, total_nxt};
      out_nxt.reply_is_total = 1'b1;
      out_valid_nxt          = 1'b1;
    end

    if (cmd.reply) begin
      out_nxt.reply          = {top[31], top};
      out_nxt.reply_is_total = 1'b0;
      out_valid_nxt          = 1'b1;
      units_nxt              = item_r.value[30:0];
    end

    if (cmd.step) begin
      if (have > units_r) begin
        // Partial trim of the top entry ends the walk
        we_rep    = 1'b1;
        wr_addr   = depth_m1[AW-1:0];
        wr_rep    = rd_rep_r - units_r[15:0];
        total_nxt = total_r - {1'b0, units_r};
        units_nxt = '0;
      end else begin
        total_nxt = total_r - {16'b0, rd_rep_r};
        units_nxt = units_r - have;
        depth_nxt = depth_m1;
      end
    end

    if (cmd.ofs) begin
      if (item_r.kind == rlso_pkg::KIND_ADD) begin
        offset_nxt = offset_r + 32'(item_r.value);
      end else begin
        offset_nxt = offset_r - 32'(item_r.value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      total_r     <= '0;
      offset_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      total_r     <= total_nxt;
      offset_r    <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    out_r   <= out_nxt;
    units_r <= units_nxt;
  end

  // Entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_val) begin
      val_mem[wr_addr] <= 32'(item_r.value) - offset_r;
    end
    if (we_rep) begin
      rep_mem[wr_addr] <= wr_rep;
    end
    rd_val_r <= val_mem[rd_addr];
    rd_rep_r <= rep_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/run_length_stack_with_offset_top.sv =====
// Top level of the run-length stack with a shared value offset.
`timescale 1ns / 1ps

// Run-length stack: each entry holds a 32-bit value and a 16-bit repeat count.
// A push transfer stores value/count on top and returns the new unit total
// (reply_is_total = 1); a push with zero count or into a full stack stores
// nothing and still returns the total. A pop transfer returns the current top
// value (0 when empty, reply_is_total = 0) and then removes the requested
// number of units (none if negative) across entries, stopping when the stack
// runs empty. Add and subtract change every stored value through one wrapping
// offset and give no result. Items are handled one at a time: a push passes
// through S_PUSH, add and subtract through S_OFS, and a pop through S_REPLY
// and, with units to remove, S_WALK, one step per emptied or trimmed entry; the
// walk reads one entry per cycle via the registered read port. The output
// register lets the next item be accepted while a result still waits; a new
// result waits for that slot. The memory needs no clearing after reset.

module run_length_stack_with_offset_top #(
  parameter int STACK_DEPTH = rlso_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlso_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlso_pkg::out_t out_data
);

  rlso_pkg::cmd_t  cmd;
  rlso_pkg::stat_t stat;

  rlso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlso_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Add/subtract never produce a result
  a_ofs_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid &&
     (in_data.kind == rlso_pkg::KIND_ADD || in_data.kind == rlso_pkg::KIND_SUB))
    |=> !out_valid)
    else $error("result appeared after add/subtract transfer");

  // A push accepted with a free output slot shows its total, registered from S_PUSH
  a_push_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid && in_data.kind == rlso_pkg::KIND_PUSH)
    |-> ##2 (out_valid && out_data.reply_is_total))
    else $error("push total missing");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.push, cmd.ofs, cmd.reply, cmd.step}))
    else $error("conflicting datapath commands");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the run-length stack with offset.
`timescale 1ns / 1ps

// Test plan
//   A directed opening covers the field extremes, every kind and the corner
//   cases: pop on an empty stack, push with a zero count, negative pop units,
//   a pop that asks for more units than are stored, a pop that crosses entries
//   and offset wraparound. Random traffic follows as short well-formed bursts
//   of pushes, pops and offset changes. One run fills the stack past full so
//   that pushes get dropped, and then pops units off it again.
//
// Checking
//   A shadow stack is updated on every accepted input transfer and queues the
//   reply it expects. Every accepted output transfer is compared field by field
//   with the oldest expected reply. Replies come in order, one per push or pop.
//
// Flow control
//   Inputs change on the falling edge and both sides are sampled on the rising
//   edge. The idle mix moves through three phases as inputs are accepted:
//   sender 37% / receiver 53%, then 53% / 37%, then no idling. At the start of
//   the last phase the receiver holds off for a long stretch while the sender
//   keeps offering, so the block backs up into its input.

module tb;

  localparam int DEPTH        = rlso_pkg::STACK_DEPTH_DEF;
  localparam int HOLD_CYCLES  = 200;   // receiver hold-off, longer than the pipeline
  localparam int QUIET_LIMIT  = 5000;  // worst walk + hold-off, several times over
  localparam int DRAIN_CYCLES = 300;   // a full-depth pop walk finishes in this
  localparam int MAX_REPORTS  = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  rlso_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rlso_pkg::out_t out_data;

  // Shadow of the stack, in stored (offset-relative) form
  logic [31:0] shadow_value [DEPTH];
  logic [15:0] shadow_repeat [DEPTH];
  int unsigned shadow_depth  = 0;
  logic [31:0] shadow_total  = '0;
  logic [31:0] shadow_offset = '0;

  rlso_pkg::in_t  pending_items[$];
  rlso_pkg::out_t expected_replies[$];

  int n_items      = 0;
  int in_accepted  = 0;
  int out_accepted = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int took_seen    = 0;  // input transfers the driver has already moved past

  run_length_stack_with_offset_top #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted item to the shadow stack and queue its reply.
  function automatic void stack_predict(rlso_pkg::in_t item);
    rlso_pkg::out_t want;
    logic [31:0]    top;
    int unsigned    units;
    int unsigned    have;
    want = '0;
    case (item.kind)
      rlso_pkg::KIND_PUSH: begin
        // zero count or full stack: nothing stored, total still returned
        if (item.repeat_req != 16'd0 && shadow_depth < DEPTH) begin
          shadow_value[shadow_depth]  = item.value - shadow_offset;
          shadow_repeat[shadow_depth] = item.repeat_req;
          shadow_depth++;
          shadow_total += 32'(item.repeat_req);
        end
        want.reply          = {1'b0, shadow_total};
        want.reply_is_total = 1'b1;
        expected_replies.push_back(want);
      end
      rlso_pkg::KIND_POP: begin
        top = '0;
        if (shadow_depth > 0) begin
          top = shadow_value[shadow_depth - 1] + shadow_offset;
        end
        want.reply          = {top[31], top};
        want.reply_is_total = 1'b0;
        expected_replies.push_back(want);
        // negative unit count removes nothing
        if (!item.value[31]) begin
          units = item.value;
          while (units > 0 && shadow_depth > 0) begin
            have = 32'(shadow_repeat[shadow_depth - 1]);
            if (have > units) begin
              shadow_repeat[shadow_depth - 1] = 16'(have - units);
              shadow_total -= units;
              units = 0;
            end else begin
              shadow_total -= have;
              units -= have;
              shadow_depth--;
            end
          end
        end
      end
      rlso_pkg::KIND_ADD: begin
        shadow_offset += item.value;
      end
      default: begin
        shadow_offset -= item.value;
      end
    endcase
  endfunction

  function automatic void queue_item(rlso_pkg::kind_t kind, logic [31:0] value,
                                     logic [15:0] count);
    rlso_pkg::in_t item;
    item.kind       = kind;
    item.value      = value;
    item.repeat_req = count;
    pending_items.push_back(item);
    n_items++;
  endfunction

  // Mostly small unit counts so the stack lives on; some huge, some negative.
  function automatic logic [31:0] random_units();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) begin
      return $urandom_range(0, 24);
    end else if (sel < 15) begin
      return $urandom_range(0, 300000);
    end else if (sel < 18) begin
      return $urandom | 32'h8000_0000;
    end
    return $urandom;
  endfunction

  function automatic logic [15:0] random_count();
    int unsigned sel;
    sel = $urandom_range(0, 29);
    if (sel == 0) begin
      return 16'd0;
    end else if (sel < 6) begin
      return 16'($urandom_range(0, 65535));
    end
    return 16'($urandom_range(1, 8));
  endfunction

  // Random bursts: pushes lean heavier than pops to keep entries around.
  function automatic void queue_random(int upto);
    int unsigned sel;
    int unsigned burst;
    while (n_items < upto) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        burst = $urandom_range(1, 6);
        repeat (burst) queue_item(rlso_pkg::KIND_PUSH, $urandom, random_count());
      end else if (sel < 7) begin
        burst = $urandom_range(1, 3);
        repeat (burst) queue_item(rlso_pkg::KIND_POP, random_units(),
                                  16'($urandom_range(0, 65535)));
      end else if (sel == 7) begin
        queue_item(rlso_pkg::KIND_ADD, $urandom, 16'($urandom_range(0, 65535)));
      end else if (sel == 8) begin
        queue_item(rlso_pkg::KIND_SUB, $urandom, 16'($urandom_range(0, 65535)));
      end else begin
        // offset change right before a read of the top
        queue_item(rlso_pkg::KIND_ADD, $urandom, 16'($urandom_range(0, 65535)));
        queue_item(rlso_pkg::KIND_POP, $urandom_range(0, 3),
                   16'($urandom_range(0, 65535)));
      end
    end
  endfunction

  function automatic int idle_phase();
    if (in_accepted * 3 < n_items) begin
      return 0;
    end else if (in_accepted * 3 < n_items * 2) begin
      return 1;
    end
    return 2;
  endfunction

  task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
    if (mismatches < MAX_REPORTS) begin
      $display("tb: mismatch in %s at result %0d: got %h, want %h",
               what, out_accepted, got, want);
    end
    mismatches++;
  endtask

  // Sender: holds a stalled item steady, otherwise offers the next one or idles.
  always @(negedge clk) begin : drive_items
    int idle_pct;
    idle_pct = (idle_phase() == 0) ? 37 : (idle_phase() == 1) ? 53 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted != took_seen) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    took_seen = in_accepted;
  end

  // Receiver: random stalls per phase, plus one long hold-off at the start of
  // the no-idle phase while the sender keeps pushing.
  always @(negedge clk) begin : stall_replies
    int idle_pct;
    idle_pct = (idle_phase() == 0) ? 53 : (idle_phase() == 1) ? 37 : 0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && idle_phase() == 2) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Monitor: check the reply first, then predict from the new input; a reply
  // can never belong to an input accepted at the same edge.
  always @(posedge clk) begin : check_replies
    rlso_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_accepted++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result", out_data.reply, '0);
        end else begin
          want = expected_replies.pop_front();
          if (out_data.reply !== want.reply) begin
            report_mismatch("reply", out_data.reply, want.reply);
          end
          if (out_data.reply_is_total !== want.reply_is_total) begin
            report_mismatch("reply_is_total", {32'b0, out_data.reply_is_total},
                            {32'b0, want.reply_is_total});
          end
        end
      end
      if (in_valid && !in_stall) begin
        stack_predict(in_data);
        in_accepted++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k;
    rst_n = 1'b0;

    // Directed opening
    queue_item(rlso_pkg::KIND_POP,  32'd5,         16'hFFFF);  // pop on empty stack
    queue_item(rlso_pkg::KIND_PUSH, 32'h7FFF_FFFF, 16'd1);     // largest value
    queue_item(rlso_pkg::KIND_PUSH, 32'h8000_0000, 16'hFFFF);  // smallest value, top count
    queue_item(rlso_pkg::KIND_PUSH, 32'd123,       16'd0);     // zero count: stores nothing
    queue_item(rlso_pkg::KIND_POP,  32'hFFFF_FFFF, 16'd0);     // negative units: top only
    queue_item(rlso_pkg::KIND_ADD,  32'h7FFF_FFFF, 16'd0);
    queue_item(rlso_pkg::KIND_POP,  32'd0,         16'd0);     // top wraps to -1
    queue_item(rlso_pkg::KIND_SUB,  32'h8000_0000, 16'd0);
    queue_item(rlso_pkg::KIND_POP,  32'h0000_FFFF, 16'd7);     // removes exactly one entry
    queue_item(rlso_pkg::KIND_POP,  32'd0,         16'd0);
    queue_item(rlso_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'd3);
    queue_item(rlso_pkg::KIND_PUSH, 32'd0,         16'h8000);
    queue_item(rlso_pkg::KIND_POP,  32'h7FFF_FFFF, 16'd0);     // more units than stored
    queue_item(rlso_pkg::KIND_POP,  32'd1,         16'd0);     // empty again
    queue_item(rlso_pkg::KIND_ADD,  32'hFFFF_FFFF, 16'd0);
    queue_item(rlso_pkg::KIND_SUB,  32'd1,         16'd0);
    queue_item(rlso_pkg::KIND_PUSH, 32'd10,        16'd2);
    queue_item(rlso_pkg::KIND_PUSH, 32'd20,        16'd3);
    queue_item(rlso_pkg::KIND_POP,  32'd4,         16'd0);     // crosses into the next entry
    queue_item(rlso_pkg::KIND_PUSH, 32'd5,         16'd2);
    queue_item(rlso_pkg::KIND_POP,  32'd1,         16'd0);     // trims the top entry
    queue_item(rlso_pkg::KIND_POP,  32'd1,         16'd0);     // finishes it
    queue_item(rlso_pkg::KIND_POP,  32'd2,         16'd0);     // runs empty part way
    queue_item(rlso_pkg::KIND_PUSH, 32'h5555_AAAA, 16'hAAAA);
    queue_item(rlso_pkg::KIND_POP,  32'h0000_AAAA, 16'h5555);

    queue_random(200);

    // Fill past full, then drain
    queue_item(rlso_pkg::KIND_POP, 32'h7FFF_FFFF, 16'($urandom_range(0, 65535)));
    for (k = 0; k < DEPTH + 6; k++) begin
      queue_item(rlso_pkg::KIND_PUSH, $urandom, 16'($urandom_range(1, 4)));
    end
    queue_item(rlso_pkg::KIND_PUSH, $urandom, 16'd0);
    queue_item(rlso_pkg::KIND_PUSH, $urandom, 16'hFFFF);
    queue_item(rlso_pkg::KIND_SUB, $urandom, 16'($urandom_range(0, 65535)));
    for (k = 0; k < 8; k++) begin
      queue_item(rlso_pkg::KIND_POP, $urandom_range(0, 200),
                 16'($urandom_range(0, 65535)));
    end

    queue_random(n_items + 80);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_accepted < n_items || expected_replies.size() != 0) begin
      @(negedge clk);
    end
    // Let a trailing offset change or pop walk settle; stray replies get caught
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rlso_pkg.sv
rtl/core/rlso_ctrl.sv
rtl/core/rlso_dp.sv
rtl/core/run_length_stack_with_offset_top.sv
tb/tb.sv
